>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the control and datapath RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CTKB_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define CTKB_ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
`else
`define CTKB_ASSERT_ALWAYS(label, cond, msg)
`define CTKB_ASSERT_IMPLY(label, pre, post, msg)
`endif
`endif

>>> hw/rtl/ctkb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ctkb_pkg;
	localparam int PULSE_W = 20;
	localparam int NOW_W   = 32;
	localparam int VAL_W   = 28;
	localparam int EST_W   = 36;
	localparam int COV_W   = 32;
	localparam int K_W     = 17;
	localparam int IN_W    = 56;
	localparam int OUT_W   = 112;

	localparam logic [2:0] REG_GAIN      = 3'd0;
	localparam logic [2:0] REG_PNOISE    = 3'd1;
	localparam logic [2:0] REG_SNOISE    = 3'd2;
	localparam logic [2:0] REG_START     = 3'd3;
	localparam logic [2:0] REG_THRESH    = 3'd4;
	localparam logic [2:0] REG_CAL_MIN   = 3'd5;
	localparam logic [2:0] REG_CAL_MAX   = 3'd6;

	localparam logic [5:0] WARMUP_SUMS   = 6'd50;
	localparam logic [4:0] DIV_LAST      = 5'd16;
	localparam logic [K_W-1:0] K_ONE     = 17'h10000;

	typedef struct packed {
		logic accept;
		logic prep;
		logic div_step;
		logic mul1;
		logic mul2;
		logic upd;
		logic trk1;
		logic trk2;
		logic wb;
	} cmd_t;

	typedef struct packed {
		logic group_done;
		logic warm;
	} status_t;
endpackage
`default_nettype wire

>>> hw/rtl/ctkb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ctkb_ctrl import ctkb_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  wire logic    m_tready,
	input  wire status_t st,
	output cmd_t         cmd
);
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_PREP = 9'b000000010,
		S_DIV  = 9'b000000100,
		S_MUL1 = 9'b000001000,
		S_MUL2 = 9'b000010000,
		S_UPD  = 9'b000100000,
		S_TRK1 = 9'b001000000,
		S_TRK2 = 9'b010000000,
		S_WB   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic [4:0] cnt_q;
	logic out_valid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.accept = s_tvalid;
				if (s_tvalid && st.group_done) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = st.warm ? S_TRK1 : S_WB;
			end
			S_TRK1: begin
				cmd.trk1 = 1'b1;
				state_d = S_TRK2;
			end
			S_TRK2: begin
				cmd.trk2 = 1'b1;
				state_d = S_WB;
			end
			S_WB: begin
				if (!out_valid_q || m_tready) begin
					cmd.wb = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) begin
				cnt_q <= cnt_q + 5'd1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.wb) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`CTKB_ASSERT_IMPLY(a_wb_slot_free, cmd.wb, !out_valid_q || m_tready, "result overwritten")
	`CTKB_ASSERT_IMPLY(a_div_len, state_q == S_DIV, cnt_q <= DIV_LAST, "divider overran")
endmodule
`default_nettype wire

>>> hw/rtl/ctkb_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ctkb_dp import ctkb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [31:0]       cfg_data,
	input  wire logic [IN_W-1:0]   in_data,
	input  wire cmd_t              cmd,
	output status_t                st,
	output logic [OUT_W-1:0]       out_data,
	output logic                   out_flag
);
	logic [7:0]  gain_q;
	logic [31:0] pnoise_q, snoise_q, cal_min_q, cal_max_q;
	logic [15:0] thresh_q;

	logic [VAL_W-1:0] sum_q, raw_q, base_q, last_q, val_q;
	logic [7:0]  group_q;
	logic [EST_W-1:0] est_q, diff_q;
	logic        neg_q;
	logic [COV_W-1:0] cov_q, p_q;
	logic [32:0] den_q;
	logic [33:0] rem_q;
	logic [K_W-1:0] k_q, nb_q;
	logic [5:0]  wcnt_q;
	logic        warm_q;
	logic [31:0] qdl_q, fdl_q, now_q;
	logic [34:0] plo_s2, phi_s2;
	logic [48:0] pk_s2;
	logic [43:0] tprod_q;

	logic [PULSE_W-1:0] pulse;
	logic [VAL_W-1:0]   sum_new, base_new;
	logic [32:0] psum;
	logic [COV_W-1:0] p_sat;
	logic [EST_W-1:0] zq;
	logic [33:0] trial;
	logic        take;
	logic [53:0] mag_full;
	logic [EST_W-1:0] mag;
	logic [5:0]  wcnt_new;
	logic        quiet, recal;

	assign pulse = in_data[PULSE_W-1:0];
	assign sum_new = sum_q + VAL_W'(pulse);
	assign st.group_done = (group_q >= gain_q);
	assign st.warm = warm_q;

	assign psum = {1'b0, cov_q} + {1'b0, pnoise_q};
	assign p_sat = psum[32] ? '1 : psum[31:0];
	assign zq = {raw_q, 8'd0};
	assign trial = {rem_q[32:0], nb_q[K_W-1]};
	assign take = (den_q != '0) && (trial >= {1'b0, den_q});
	assign mag_full = {1'b0, phi_s2, 18'd0} + {19'd0, plo_s2};
	assign mag = mag_full[51:16];
	assign wcnt_new = wcnt_q + 6'd1;

	assign quiet = {val_q - base_q, 16'd0} < tprod_q;
	assign recal = (val_q >= base_q) &&
		((now_q >= qdl_q && quiet) || (now_q >= fdl_q));
	assign base_new = (val_q < base_q || recal) ? val_q : base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
			pnoise_q <= 32'd655;
			snoise_q <= 32'd65536;
			thresh_q <= 16'd1311;
			cal_min_q <= 32'd1000;
			cal_max_q <= 32'd10000;
			sum_q <= '0;
			group_q <= '0;
			est_q <= '0;
			cov_q <= '0;
			wcnt_q <= '0;
			warm_q <= 1'b0;
			base_q <= '0;
			qdl_q <= '0;
			fdl_q <= '0;
			last_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GAIN:    gain_q <= cfg_data[7:0];
					REG_PNOISE:  pnoise_q <= cfg_data;
					REG_SNOISE:  snoise_q <= cfg_data;
					REG_START:   est_q <= {20'd0, cfg_data[7:0], 8'd0};
					REG_THRESH:  thresh_q <= cfg_data[15:0];
					REG_CAL_MIN: cal_min_q <= cfg_data;
					REG_CAL_MAX: cal_max_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				if (st.group_done) begin
					sum_q <= '0;
					group_q <= '0;
				end else begin
					sum_q <= sum_new;
					group_q <= group_q + 8'd1;
				end
			end
			if (cmd.upd) begin
				est_q <= neg_q ? est_q - mag : est_q + mag;
				cov_q <= pk_s2[47:16];
				if (!warm_q) begin
					wcnt_q <= wcnt_new;
					if (wcnt_new >= WARMUP_SUMS) begin
						warm_q <= 1'b1;
					end
				end
			end
			if (cmd.trk2) begin
				base_q <= base_new;
				last_q <= val_q - base_new;
				if (recal) begin
					qdl_q <= now_q + cal_min_q;
					fdl_q <= now_q + cal_max_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && st.group_done) begin
			raw_q <= sum_new;
			now_q <= in_data[IN_W-5:PULSE_W];
		end
		if (cmd.prep) begin
			p_q <= p_sat;
			den_q <= {1'b0, p_sat} + {1'b0, snoise_q};
			rem_q <= {3'd0, p_sat[31:1]};
			nb_q <= {p_sat[0], 16'd0};
			k_q <= '0;
			neg_q <= (zq < est_q);
			diff_q <= (zq < est_q) ? est_q - zq : zq - est_q;
		end
		if (cmd.div_step) begin
			rem_q <= take ? trial - {1'b0, den_q} : trial;
			nb_q <= {nb_q[K_W-2:0], 1'b0};
			k_q <= {k_q[K_W-2:0], take};
		end
		if (cmd.mul1) begin
			plo_s2 <= diff_q[17:0] * k_q;
			pk_s2 <= (K_ONE - k_q) * p_q;
		end
		if (cmd.mul2) begin
			phi_s2 <= diff_q[35:18] * k_q;
		end
		if (cmd.trk1) begin
			val_q <= est_q[35:8];
			tprod_q <= thresh_q * base_q;
		end
		if (cmd.wb) begin
			out_data <= {last_q, base_q, est_q[35:8], raw_q};
			out_flag <= warm_q;
		end
	end

	`CTKB_ASSERT_IMPLY(a_k_range, cmd.mul1, k_q <= K_ONE, "gain above one")
	`CTKB_ASSERT_ALWAYS(a_warm_holds, !$fell(warm_q), "warm flag cleared")
endmodule
`default_nettype wire

>>> hw/rtl/cap_touch_kalman_baseline.sv
// Channel   Direction  Signals                        Contents
// input     in         s_tvalid s_tready s_tdata      one charge time and time stamp
// output    out        m_tvalid m_tready m_tdata/user one result per completed group
// config    in         cfg_we cfg_index cfg_data      register write, no read-back
//
// A sample that does not complete a group is taken in idle; the block stays ready for more.
// A sample that completes a group runs prep, the divider, the multiplies, update, tracking
// once warm, and write-back, with a 17-step restoring divider for the Kalman gain.
// A finished result waits in an output register while the next samples are taken.
// Reset is asynchronous and active low; it loads the default register values.
`timescale 1ns / 1ps
`default_nettype none
module cap_touch_kalman_baseline import ctkb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_W-1:0]   s_tdata,  // pulse_time, now_ms
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata,  // raw_sum, filtered, base_level, touch_value
	output logic                   m_tuser,  // ready_res
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [31:0]       cfg_data
);
	cmd_t    cmd;
	status_t st;

	ctkb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	ctkb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.st        (st),
		.out_data  (m_tdata),
		.out_flag  (m_tuser)
	);
endmodule
`default_nettype wire
